### hdl/mtt_pkg.sv
// ---------------------------------------------------------------------------
// mtt_pkg: shared types and constants for the map text tokenizer
// Token kinds, character codes, and the token bundle that is passed from the
// scanner through the queue to the serializer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

    // token kinds
    localparam logic [3:0] K_STRING = 4'd0;
    localparam logic [3:0] K_NUMBER = 4'd1;
    localparam logic [3:0] K_IDENT  = 4'd2;
    localparam logic [3:0] K_LPAREN = 4'd3;
    localparam logic [3:0] K_RPAREN = 4'd4;
    localparam logic [3:0] K_LBRACE = 4'd5;
    localparam logic [3:0] K_RBRACE = 4'd6;
    localparam logic [3:0] K_END    = 4'd7;
    localparam logic [3:0] K_ERROR  = 4'd8;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // queue between scanner and serializer
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } t_token;

    // all tokens caused by one text byte, slot 0 first
    typedef struct packed {
        logic [1:0]   count;
        t_token [2:0] toks;
    } t_bundle;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a)) ||
               (c == CH_UNDER);
    endfunction

endpackage

`default_nettype wire

### hdl/mtt_scan.sv
// ---------------------------------------------------------------------------
// mtt_scan: byte classifier and scan state machine
// One text byte per cycle while i_accept is high; bundles the tokens it ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtt_scan #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_byte,
    output mtt_pkg::t_bundle      o_bundle,
    output logic                  o_push
);
    import mtt_pkg::*;

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_INT     = 8'b0000_0010,
        M_DOT     = 8'b0000_0100,
        M_FRAC    = 8'b0000_1000,
        M_IDENT   = 8'b0001_0000,
        M_STR     = 8'b0010_0000,
        M_SLASH   = 8'b0100_0000,
        M_COMMENT = 8'b1000_0000
    } t_mode;

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_begin, n_begin;
    logic [OFFSET_BITS-1:0] pm1;
    logic [1:0]             pre_cnt;
    t_token                 pre0, pre1, rs_tok;
    logic                   rescan, rs_valid;
    t_bundle                bundle;

    function automatic t_token mk_tok(input logic [3:0] kind,
                                      input logic [OFFSET_BITS-1:0] start,
                                      input logic [OFFSET_BITS-1:0] len);
        t_token                 t;
        logic [OFFSET_BITS+15:0] s;
        logic [OFFSET_BITS+15:0] l;
        s = {16'b0, start};
        l = {16'b0, len};
        t.kind   = kind;
        t.start  = s[15:0];
        t.length = l[15:0];
        return t;
    endfunction

    assign pm1 = r_pos - OFFSET_BITS'(1);

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos + OFFSET_BITS'(1);
        n_begin  = r_begin;
        pre_cnt  = 2'd0;
        pre0     = '0;
        pre1     = '0;
        rescan   = 1'b0;
        rs_valid = 1'b0;
        rs_tok   = '0;

        unique case (r_mode)
            M_INT, M_FRAC: begin
                if (is_digit(i_byte)) begin
                    n_mode = r_mode;
                end else if (r_mode == M_INT && i_byte == CH_DOT) begin
                    n_mode = M_DOT;
                end else begin
                    pre0    = mk_tok(K_NUMBER, r_begin, r_pos - r_begin);
                    pre_cnt = 2'd1;
                    rescan  = 1'b1;
                end
            end
            M_DOT: begin
                if (is_digit(i_byte)) begin
                    n_mode = M_FRAC;
                end else begin
                    // number ends before the dot, dot becomes an error token
                    pre0    = mk_tok(K_NUMBER, r_begin, pm1 - r_begin);
                    pre1    = mk_tok(K_ERROR, pm1, OFFSET_BITS'(1));
                    pre_cnt = 2'd2;
                    rescan  = 1'b1;
                end
            end
            M_IDENT: begin
                if (!(is_letter(i_byte) || is_digit(i_byte))) begin
                    pre0    = mk_tok(K_IDENT, r_begin, r_pos - r_begin);
                    pre_cnt = 2'd1;
                    rescan  = 1'b1;
                end
            end
            M_STR: begin
                // an open string at end of text is dropped
                if (i_byte == CH_NUL) begin
                    rescan = 1'b1;
                end else if (i_byte == CH_QUOTE) begin
                    pre0    = mk_tok(K_STRING, r_begin,
                                     r_pos + OFFSET_BITS'(1) - r_begin);
                    pre_cnt = 2'd1;
                    n_mode  = M_IDLE;
                end
            end
            M_SLASH: begin
                if (i_byte == CH_SLASH) begin
                    n_mode = M_COMMENT;
                end else begin
                    pre0    = mk_tok(K_ERROR, pm1, OFFSET_BITS'(1));
                    pre_cnt = 2'd1;
                    rescan  = 1'b1;
                end
            end
            M_COMMENT: begin
                if (i_byte == CH_LF) begin
                    n_mode = M_IDLE;
                end else if (i_byte == CH_NUL) begin
                    rescan = 1'b1;
                end
            end
            default: begin
                rescan = 1'b1;
            end
        endcase

        if (rescan) begin
            n_mode = M_IDLE;
            priority if (i_byte == CH_NUL) begin
                rs_valid = 1'b1;
                rs_tok   = mk_tok(K_END, r_pos, '0);
                n_pos    = '0;
                n_begin  = '0;
            end else if (i_byte == CH_SPACE || i_byte == CH_TAB ||
                         i_byte == CH_CR || i_byte == CH_LF) begin
                rs_valid = 1'b0;
            end else if (i_byte == CH_SLASH) begin
                n_mode = M_SLASH;
            end else if (i_byte == CH_LPAREN) begin
                rs_valid = 1'b1;
                rs_tok   = mk_tok(K_LPAREN, r_pos, OFFSET_BITS'(1));
            end else if (i_byte == CH_RPAREN) begin
                rs_valid = 1'b1;
                rs_tok   = mk_tok(K_RPAREN, r_pos, OFFSET_BITS'(1));
            end else if (i_byte == CH_LBRACE) begin
                rs_valid = 1'b1;
                rs_tok   = mk_tok(K_LBRACE, r_pos, OFFSET_BITS'(1));
            end else if (i_byte == CH_RBRACE) begin
                rs_valid = 1'b1;
                rs_tok   = mk_tok(K_RBRACE, r_pos, OFFSET_BITS'(1));
            end else if (i_byte == CH_QUOTE) begin
                n_begin = r_pos;
                n_mode  = M_STR;
            end else if (is_digit(i_byte) || i_byte == CH_MINUS) begin
                n_begin = r_pos;
                n_mode  = M_INT;
            end else if (is_letter(i_byte)) begin
                n_begin = r_pos;
                n_mode  = M_IDENT;
            end else begin
                rs_valid = 1'b1;
                rs_tok   = mk_tok(K_ERROR, r_pos, OFFSET_BITS'(1));
            end
        end

        // rescan token goes right after the tokens closed by the old mode
        bundle.count = pre_cnt + {1'b0, rs_valid};
        bundle.toks  = '0;
        bundle.toks[0] = pre0;
        bundle.toks[1] = pre1;
        unique case (pre_cnt)
            2'd0:    bundle.toks[0] = rs_tok;
            2'd1:    bundle.toks[1] = rs_tok;
            default: bundle.toks[2] = rs_tok;
        endcase
    end

    assign o_bundle = bundle;
    assign o_push   = i_accept && (bundle.count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
        end
    end

endmodule

`default_nettype wire

### hdl/mtt_queue.sv
// ---------------------------------------------------------------------------
// mtt_queue: token bundle queue
// Short queue that decouples the scanner from the token serializer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtt_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire mtt_pkg::t_bundle i_data,
    input  wire logic             i_pop,
    output mtt_pkg::t_bundle      o_head,
    output logic                  o_full,
    output logic                  o_empty
);
    import mtt_pkg::*;

    t_bundle           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/mtt_serial.sv
// ---------------------------------------------------------------------------
// mtt_serial: token serializer
// Walks the tokens of the head bundle one per transfer and marks the last.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtt_serial (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mtt_pkg::t_bundle i_head,
    input  wire logic             i_q_empty,
    input  wire logic             i_pop,
    output logic                  o_deq,
    output logic                  o_empty,
    output logic [3:0]            o_token_kind,
    output logic [15:0]           o_token_start,
    output logic [15:0]           o_token_length,
    output logic                  o_last_of_run
);
    import mtt_pkg::*;

    logic [1:0] r_idx;
    t_token     tok;
    logic       last, take;

    assign tok     = i_head.toks[r_idx];
    assign last    = (r_idx == i_head.count - 2'd1);
    assign take    = i_pop && !i_q_empty;
    assign o_deq   = take && last;
    assign o_empty = i_q_empty;

    assign o_token_kind   = tok.kind;
    assign o_token_start  = tok.start;
    assign o_token_length = tok.length;
    assign o_last_of_run  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

`default_nettype wire

### hdl/map_text_tokenizer.sv
// ---------------------------------------------------------------------------
// map_text_tokenizer: streaming tokenizer for map text
// Input channel: push i_text_byte while o_full is low; one byte per cycle.
//   A zero byte ends the text; offsets then restart at 0 for the next text.
// Output channel: while o_empty is low the oldest token is on o_token_*;
//   i_pop takes it. o_last_of_run marks the final token caused by one byte.
// Path: the scanner is combinational and the queue registers the bundle,
//   so with the queue empty a token is on the outputs right after the edge
//   that transfers the byte that ends it.
// Throughput: one byte per cycle on input while o_full is low; the output side
//   delivers one token per cycle while i_pop is high, so bytes ending up to
//   three tokens are limited by the serializer and four-entry bundle queue.
// Reset: synchronous, clears scan mode, offsets and the queue.
// Stall: when the receiver holds off, the queue fills and o_full rises;
//   the scanner keeps its state until bytes are accepted again.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module map_text_tokenizer #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [3:0]       o_token_kind,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic             o_last_of_run
);
    import mtt_pkg::*;

    t_bundle scan_bundle, head;
    logic    scan_push, q_full, q_empty, deq, accept;

    assign accept = i_push && !q_full;
    assign o_full = q_full;

    mtt_scan #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_text_byte),
        .o_bundle (scan_bundle),
        .o_push   (scan_push)
    );

    mtt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (scan_push),
        .i_data  (scan_bundle),
        .i_pop   (deq),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mtt_serial u_serial (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_empty      (q_empty),
        .i_pop          (i_pop),
        .o_deq          (deq),
        .o_empty        (o_empty),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

`default_nettype wire

### bench/tb_map_text_tokenizer.sv
// ---------------------------------------------------------------------------
// tb_map_text_tokenizer: self-checking bench for the map text tokenizer
// Streams text bytes through the push/full side and predicts every token
// with a cycle-free scanner model. Tokens taken from the empty/pop side are
// compared field by field, in order. Both sides idle at random, and the
// receiver holds off once so the block backs up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_map_text_tokenizer;

    import mtt_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    localparam int MAX_GAP      = 18;
    localparam int HOLD_CYCLES  = 100;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 370;
    localparam int MAX_PRINTS   = 50;

    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_Z  = "Z";
    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] CH_LOW_Z = "z";
    localparam logic [7:0] CH_HIGH  = 8'hff;
    localparam logic [7:0] CH_SOH   = 8'h01;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_INT,
        SC_DOT,
        SC_FRAC,
        SC_IDENT,
        SC_STR,
        SC_SLASH,
        SC_COMMENT
    } t_scan_state;

    typedef struct {
        logic [7:0] text_byte;
        int         gap;
    } t_text_item;

    typedef struct {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } t_exp_token;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic [7:0]  i_text_byte = 8'h00;
    logic        i_pop = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [3:0]  o_token_kind;
    logic [15:0] o_token_start;
    logic [15:0] o_token_length;
    logic        o_last_of_run;

    map_text_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_text_byte    (i_text_byte),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    t_text_item pending_text[$];
    t_exp_token byte_tokens[$];
    t_exp_token expected_tokens[$];

    t_scan_state scan_state = SC_IDLE;
    logic [15:0] next_pos = 16'd0;
    logic [15:0] tok_begin = 16'd0;

    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int holds_asked = 0;
    int bytes_queued = 0;
    int mismatches = 0;

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
               (c == CH_UNDER);
    endfunction

    // random non-zero byte other than the one that would close the construct
    function automatic logic [7:0] any_byte_but(input logic [7:0] banned);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == banned);
        return b;
    endfunction

    function automatic logic [7:0] word_char(input logic first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26) return 8'(CH_UP_A + r);
        if (r < 52) return 8'(CH_LOW_A + (r - 26));
        if (r == 52) return CH_UNDER;
        return 8'(CH_ZERO + (r - 53));
    endfunction

    task automatic note_token(input logic [3:0] kind, input logic [15:0] start,
                              input logic [15:0] length);
        t_exp_token t;
        t.kind = kind;
        t.start = start;
        t.length = length;
        t.last = 1'b0;
        byte_tokens.push_back(t);
    endtask

    // byte c at offset p seen with no token open
    task automatic start_token(input logic [7:0] c, input logic [15:0] p);
        scan_state = SC_IDLE;
        case (c)
            CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
                // separators are skipped
            end
            CH_SLASH:  scan_state = SC_SLASH;
            CH_LPAREN: note_token(K_LPAREN, p, 16'd1);
            CH_RPAREN: note_token(K_RPAREN, p, 16'd1);
            CH_LBRACE: note_token(K_LBRACE, p, 16'd1);
            CH_RBRACE: note_token(K_RBRACE, p, 16'd1);
            CH_QUOTE: begin
                tok_begin = p;
                scan_state = SC_STR;
            end
            default: begin
                if (is_numeral(c) || c == CH_MINUS) begin
                    tok_begin = p;
                    scan_state = SC_INT;
                end else if (is_word_start(c)) begin
                    tok_begin = p;
                    scan_state = SC_IDENT;
                end else begin
                    note_token(K_ERROR, p, 16'd1);
                end
            end
        endcase
    endtask

    // advance the scanner by one transferred byte and queue its tokens
    task automatic scan_byte(input logic [7:0] c);
        logic [15:0] p;
        logic [15:0] p_prev;
        logic        rescan;
        p = next_pos;
        p_prev = next_pos - 16'd1;
        rescan = 1'b0;
        byte_tokens.delete();
        case (scan_state)
            SC_INT, SC_FRAC: begin
                if (scan_state == SC_INT && c == CH_DOT) begin
                    scan_state = SC_DOT;
                end else if (!is_numeral(c)) begin
                    note_token(K_NUMBER, tok_begin, p - tok_begin);
                    rescan = 1'b1;
                end
            end
            SC_DOT: begin
                if (is_numeral(c)) begin
                    scan_state = SC_FRAC;
                end else begin
                    // the number ends before the dot, the dot is an error
                    note_token(K_NUMBER, tok_begin, p_prev - tok_begin);
                    note_token(K_ERROR, p_prev, 16'd1);
                    rescan = 1'b1;
                end
            end
            SC_IDENT: begin
                if (!is_word_start(c) && !is_numeral(c)) begin
                    note_token(K_IDENT, tok_begin, p - tok_begin);
                    rescan = 1'b1;
                end
            end
            SC_STR: begin
                if (c == CH_NUL) begin
                    rescan = 1'b1;
                end else if (c == CH_QUOTE) begin
                    note_token(K_STRING, tok_begin, p + 16'd1 - tok_begin);
                    scan_state = SC_IDLE;
                end
            end
            SC_SLASH: begin
                if (c == CH_SLASH) begin
                    scan_state = SC_COMMENT;
                end else begin
                    note_token(K_ERROR, p_prev, 16'd1);
                    rescan = 1'b1;
                end
            end
            SC_COMMENT: begin
                if (c == CH_LF) scan_state = SC_IDLE;
                else if (c == CH_NUL) rescan = 1'b1;
            end
            default: rescan = 1'b1;
        endcase

        if (rescan && c == CH_NUL) begin
            note_token(K_END, p, 16'd0);
            scan_state = SC_IDLE;
            next_pos = 16'd0;
            tok_begin = 16'd0;
        end else begin
            if (rescan) start_token(c, p);
            next_pos = p + 16'd1;
        end

        if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        t_text_item it;
        it.text_byte = b;
        it.gap = $urandom_range(0, tx_gap_max);
        pending_text.push_back(it);
        bytes_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_token();
        t_exp_token want;
        if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected token, kind", int'(o_token_kind), 0);
            return;
        end
        want = expected_tokens.pop_front();
        if (o_token_kind != want.kind)
            report_mismatch("kind", int'(o_token_kind), int'(want.kind));
        if (o_token_start != want.start)
            report_mismatch("start", int'(o_token_start), int'(want.start));
        if (o_token_length != want.length)
            report_mismatch("length", int'(o_token_length), int'(want.length));
        if (o_last_of_run != want.last)
            report_mismatch("last_of_run", int'(o_last_of_run), int'(want.last));
    endtask

    task automatic wait_idle();
        while (pending_text.size() != 0 || i_push || expected_tokens.size() != 0)
            @(posedge i_clk);
    endtask

    // byte driver: each byte waits out its own gap before it is offered
    int   tx_wait = 0;
    logic tx_loaded = 1'b0;

    always @(posedge i_clk) begin
        logic       offering;
        logic [7:0] nxt_byte;
        t_text_item it;
        offering = i_push;
        nxt_byte = i_text_byte;
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                scan_byte(i_text_byte);
                offering = 1'b0;
            end
            if (!offering) begin
                nxt_byte = 8'($urandom_range(0, 255));
                if (pending_text.size() > 0) begin
                    if (!tx_loaded) begin
                        tx_wait = pending_text[0].gap;
                        tx_loaded = 1'b1;
                    end
                    if (tx_wait == 0) begin
                        it = pending_text.pop_front();
                        nxt_byte = it.text_byte;
                        offering = 1'b1;
                        tx_loaded = 1'b0;
                    end else begin
                        tx_wait--;
                    end
                end
            end
        end
        i_push <= offering;
        i_text_byte <= nxt_byte;
    end

    // token monitor: checks each transfer, then draws its own wait
    int rx_wait = 0;
    int hold_left = 0;
    int holds_done = 0;

    always @(posedge i_clk) begin
        logic ready;
        ready = 1'b0;
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                check_token();
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (holds_done != holds_asked) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end else begin
                ready = 1'b1;
            end
        end
        i_pop <= ready;
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("map_text_tokenizer regression: fail");
            $finish;
        end
    end

    initial begin
        int sel;
        int k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every kind, dot without digit, lone slash, high and control bytes,
        // three tokens on one byte, unterminated string, comment ended by end of text
        tx_gap_max = 3;
        rx_gap_max = 3;
        queue_text("(){}\"a\"-5.x_/.");
        queue_byte(CH_HIGH);
        queue_byte(CH_SOH);
        queue_byte(CH_NUL);
        queue_text("3.");
        queue_byte(CH_NUL);
        queue_text("\"b");
        queue_byte(CH_NUL);
        queue_text("//");
        queue_byte(CH_NUL);
        wait_idle();

        // receiver stalls while brackets stream in back to back
        tx_gap_max = 0;
        holds_asked++;
        for (k = 0; k < 24; k++) queue_byte(k[0] ? CH_LBRACE : CH_RPAREN);
        wait_idle();

        bytes_queued = 0;
        while (bytes_queued < RANDOM_BYTES) begin
            k = $urandom_range(0, 2);
            tx_gap_max = (k == 0) ? 0 : (k == 1) ? 4 : MAX_GAP;
            k = $urandom_range(0, 2);
            rx_gap_max = (k == 0) ? 0 : (k == 1) ? 4 : MAX_GAP;
            repeat ($urandom_range(4, 30)) begin
                if (bytes_queued >= RANDOM_BYTES) break;
                sel = $urandom_range(0, 99);
                if (sel < 20) begin
                    if ($urandom_range(0, 2) == 0) queue_byte(CH_MINUS);
                    repeat ($urandom_range(1, 4))
                        queue_byte(8'(CH_ZERO + $urandom_range(0, 9)));
                    k = $urandom_range(0, 5);
                    if (k < 2) begin
                        queue_byte(CH_DOT);
                        repeat ($urandom_range(1, 3))
                            queue_byte(8'(CH_ZERO + $urandom_range(0, 9)));
                    end else if (k == 2) begin
                        queue_byte(CH_DOT);
                    end
                end else if (sel < 38) begin
                    queue_byte(word_char(1'b1));
                    repeat ($urandom_range(0, 6)) queue_byte(word_char(1'b0));
                end else if (sel < 53) begin
                    k = $urandom_range(0, 3);
                    queue_byte(k == 0 ? CH_LPAREN : k == 1 ? CH_RPAREN :
                               k == 2 ? CH_LBRACE : CH_RBRACE);
                end else if (sel < 63) begin
                    queue_byte(CH_QUOTE);
                    repeat ($urandom_range(0, 6)) queue_byte(any_byte_but(CH_QUOTE));
                    queue_byte(CH_QUOTE);
                end else if (sel < 70) begin
                    queue_text("//");
                    repeat ($urandom_range(0, 6)) queue_byte(any_byte_but(CH_LF));
                    queue_byte(CH_LF);
                end else if (sel < 75) begin
                    queue_byte(CH_SLASH);
                end else if (sel < 85) begin
                    queue_byte(8'($urandom_range(1, 255)));
                end else begin
                    k = $urandom_range(0, 3);
                    queue_byte(k == 0 ? CH_SPACE : k == 1 ? CH_TAB : k == 2 ? CH_CR : CH_LF);
                end
                if ($urandom_range(0, 2) == 0) queue_byte(CH_SPACE);
            end
            // some texts run on into the next burst without an end byte
            if ($urandom_range(0, 5) != 0) queue_byte(CH_NUL);
            while (pending_text.size() != 0) @(posedge i_clk);
        end
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("map_text_tokenizer regression: pass");
        end else begin
            $display("map_text_tokenizer regression: fail");
        end
        $finish;
    end

endmodule

### map_text_tokenizer.f
hdl/mtt_pkg.sv
hdl/mtt_scan.sv
hdl/mtt_queue.sv
hdl/mtt_serial.sv
hdl/map_text_tokenizer.sv
bench/tb_map_text_tokenizer.sv
